@@ sv/bilinear_image_scaler_macros.svh @@
// Assertion macros for the bilinear image scaler.
// No dependencies.
`ifndef BILINEAR_IMAGE_SCALER_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_MACROS_SVH
// implication checked on every edge outside reset
`define BIS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BIS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/bis_pkg.sv @@
// Shared types and constants for the bilinear image scaler.
// No dependencies.
package bis_pkg;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_STEP   = 2'd3;
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_WAIT, ST_OUT
  } be_state_t;
endpackage

@@ sv/bilinear_image_scaler.sv @@
// Bilinear image scaler top level: config registers, front end, queue, back end.
// Depends on bis_pkg, bis_front, bis_back and the assertion macro header.
// Channels: in_ (tdata = row, col, blue, green, red; tuser = action) and
//   out_ (tdata = out_blue, out_green, out_red). Config is a plain write port.
// A write beat in range stores one pixel in the frame memory and gives no result.
// A request beat is located and placed in a two-entry queue; the back end
//   reads the four neighbors through the frame memory's read port, one per
//   cycle, and accumulates the weighted channels.
// A request takes the back end through idle, four serial reads, blend and
//   output, where out_tvalid is high; the next request starts only after
//   out_tready takes the result, while the queue may already hold it.
// A write beat is taken only while no request is queued or in flight, so it
//   never overtakes an earlier request; otherwise writes go one per cycle.
// Reset (rst_n low, synchronous) empties the queue and restores the
//   config registers to 256, 256, 1.0, 1.0; frame memory is not cleared.
// When out_tready is low the result holds and the queue fills, then
//   in_tready drops.
module bilinear_image_scaler #(
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,  // row, col, blue, green, red
  input  logic                           in_tuser,  // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata, // out_blue, out_green, out_red
  input  logic                           cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bis_pkg::*;
  `include "bilinear_image_scaler_macros.svh"
  localparam int unsigned WB = $clog2(MAX_WIDTH);
  localparam int unsigned HB = $clog2(MAX_HEIGHT);
  localparam int unsigned QW = 2*HB + 2*WB + 2*FRAC_BITS;

  logic [8:0] src_w_r, src_h_r;
  logic [23:0] row_step_r, col_step_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd256; src_h_r <= 9'd256;
      row_step_r <= 24'd65536; col_step_r <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w_r <= cfg_data[8:0];
        REG_SRC_HEIGHT: src_h_r <= cfg_data[8:0];
        REG_ROW_STEP:   row_step_r <= cfg_data;
        REG_COL_STEP:   col_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [11:0] f_row, f_col;
  assign f_row = in_tdata[11:0];
  assign f_col = in_tdata[23:12];
  logic [WB:0] w_eff;
  logic [HB:0] h_eff;
  always_comb begin
    if (src_w_r < 9'd2) w_eff = (WB+1)'(2);
    else if (13'(src_w_r) > 13'(MAX_WIDTH)) w_eff = (WB+1)'(MAX_WIDTH);
    else w_eff = (WB+1)'(src_w_r);
    if (src_h_r < 9'd2) h_eff = (HB+1)'(2);
    else if (13'(src_h_r) > 13'(MAX_HEIGHT)) h_eff = (HB+1)'(MAX_HEIGHT);
    else h_eff = (HB+1)'(src_h_r);
  end

  logic acc;
  assign acc = in_tvalid && in_tready;
  logic [HB-1:0] r0, r1;
  logic [WB-1:0] c0, c1;
  logic [FRAC_BITS-1:0] fr, fc;
  bis_front #(.IDXW(HB), .FRAC(FRAC_BITS)) u_row (
    .step(row_step_r), .idx(f_row), .size(h_eff),
    .base(r0), .nb(r1), .frac(fr));
  bis_front #(.IDXW(WB), .FRAC(FRAC_BITS)) u_col (
    .step(col_step_r), .idx(f_col), .size(w_eff),
    .base(c0), .nb(c1), .frac(fc));

  // two-entry request queue
  logic [QW-1:0] q_mem_r [2];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  logic q_push, q_pop, q_ready;
  assign in_tready = (q_cnt_r != 2'd2)
                   && !((in_tuser == ACT_WRITE) && (q_cnt_r != 2'd0));
  assign q_push = acc && (in_tuser == ACT_REQUEST);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r <= 1'b0; q_rp_r <= 1'b0; q_cnt_r <= 2'd0;
    end else begin
      if (q_push) q_wp_r <= ~q_wp_r;
      if (q_pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(q_push) - 2'(q_pop);
    end
    if (q_push) q_mem_r[q_wp_r] <= {r0, r1, c0, c1, fr, fc};
  end
  logic [QW-1:0] qh;
  assign qh = q_mem_r[q_rp_r];
  assign q_pop = q_ready;

  logic wr_en;
  assign wr_en = acc && (in_tuser == ACT_WRITE) && (13'(f_row) < 13'(MAX_HEIGHT))
               && (13'(f_col) < 13'(MAX_WIDTH));
  bis_back #(.WB(WB), .HB(HB), .FRAC(FRAC_BITS)) u_back (
    .clk, .rst_n, .wr_en, .wr_addr({f_row[HB-1:0], f_col[WB-1:0]}),
    .wr_data(in_tdata[47:24]), .q_valid(q_cnt_r != 2'd0), .q_ready,
    .r0(qh[QW-1 -: HB]), .r1(qh[QW-HB-1 -: HB]),
    .c0(qh[2*WB+2*FRAC_BITS-1 -: WB]), .c1(qh[WB+2*FRAC_BITS-1 -: WB]),
    .fr(qh[2*FRAC_BITS-1 -: FRAC_BITS]), .fc(qh[FRAC_BITS-1:0]),
    .o_valid(out_tvalid), .o_ready(out_tready), .o_data(out_tdata));

  `BIS_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, q_cnt_r != 2'd3)
  `BIS_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, q_cnt_r != 2'd0)
  `BIS_ASSERT_NXT(a_full_stall, clk, rst_n, q_cnt_r == 2'd2 && !q_pop, !in_tready)
endmodule

@@ sv/bis_front.sv @@
// Front end: locates the source position on one axis.
// Depends on bis_pkg.
module bis_front #(
  parameter int unsigned IDXW = 8,
  parameter int unsigned FRAC = 16
) (
  input  logic [23:0]                 step,
  input  logic [11:0]                 idx,
  input  logic [IDXW:0]               size,
  output logic [IDXW-1:0]             base,
  output logic [IDXW-1:0]             nb,
  output logic [FRAC-1:0]             frac
);
  import bis_pkg::*;
  localparam int unsigned PW = 36;
  logic [PW-1:0] pos;
  logic [PW-FRAC-1:0] ip;
  logic [IDXW:0] last;
  logic [IDXW:0] b;
  assign pos  = PW'(step) * PW'(idx);
  assign ip   = pos[PW-1:FRAC];
  assign last = size - (IDXW+1)'(1);
  always_comb begin
    if (ip > (PW-FRAC)'(last)) begin
      b = last;
      frac = '0;
    end else begin
      b = ip[IDXW:0];
      frac = pos[FRAC-1:0];
    end
    base = b[IDXW-1:0];
    nb = (b == last) ? IDXW'(b - 1'b1) : IDXW'(b + 1'b1);
  end
endmodule

@@ sv/bis_back.sv @@
// Back end: frame memory, four neighbor reads, blend of the channels.
// Depends on bis_pkg.
module bis_back #(
  parameter int unsigned WB = 8,
  parameter int unsigned HB = 8,
  parameter int unsigned FRAC = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [HB+WB-1:0]     wr_addr,
  input  logic [23:0]          wr_data,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [HB-1:0]        r0, r1,
  input  logic [WB-1:0]        c0, c1,
  input  logic [FRAC-1:0]      fr, fc,
  output logic                 o_valid,
  input  logic                 o_ready,
  output logic [23:0]          o_data
);
  import bis_pkg::*;
  localparam int unsigned WW = FRAC + 1;
  localparam int unsigned AW = 2*WW + 10;
  logic [23:0] mem [2**(HB+WB)];
  be_state_t st_r, st_nxt;
  logic [HB+WB-1:0] raddr;
  logic [23:0] rd_r;
  logic [WW-1:0] wgt_r, wgt_nxt;
  logic [AW-1:0] acc_r [3], acc_nxt [3];
  logic [WW-1:0] wr_f, wc_f;
  logic [2*WW-1:0] wprod;
  logic [1:0] tap_nxt;
  logic rd_v_r, rd_v_nxt;
  logic [23:0] od_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[raddr];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_RD0;
      ST_RD0:  st_nxt = ST_RD1;
      ST_RD1:  st_nxt = ST_RD2;
      ST_RD2:  st_nxt = ST_RD3;
      ST_RD3:  st_nxt = ST_WAIT;
      ST_WAIT: st_nxt = ST_OUT;
      ST_OUT:  if (o_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    raddr = {r0, c0};
    tap_nxt = 2'd0;
    rd_v_nxt = 1'b0;
    case (st_r)
      ST_RD0: begin raddr = {r0, c0}; tap_nxt = 2'd0; rd_v_nxt = 1'b1; end
      ST_RD1: begin raddr = {r0, c1}; tap_nxt = 2'd1; rd_v_nxt = 1'b1; end
      ST_RD2: begin raddr = {r1, c0}; tap_nxt = 2'd2; rd_v_nxt = 1'b1; end
      ST_RD3: begin raddr = {r1, c1}; tap_nxt = 2'd3; rd_v_nxt = 1'b1; end
      default: ;
    endcase
    wr_f = tap_nxt[1] ? WW'(fr) : (WW'(1) << FRAC) - WW'(fr);
    wc_f = tap_nxt[0] ? WW'(fc) : (WW'(1) << FRAC) - WW'(fc);
    wprod = (2*WW)'(wr_f) * (2*WW)'(wc_f);
    wgt_nxt = WW'(wprod >> FRAC);
  end

  // weight product registered with fraction bits kept in a side register
  logic [FRAC-1:0] wlo_r;
  logic [2*WW-2:0] wfull;
  assign wfull = {wgt_r, wlo_r};
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = acc_r[k];
      if (st_r == ST_RD0) acc_nxt[k] = '0;
      else if (rd_v_r)
        acc_nxt[k] = acc_r[k] + AW'(wfull[2*WW-2:0] * AW'(rd_r[8*k +: 8]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rd_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rd_v_r <= rd_v_nxt;
    end
    wgt_r <= wgt_nxt;
    wlo_r <= wprod[FRAC-1:0];
    for (int k = 0; k < 3; k++) acc_r[k] <= acc_nxt[k];
    if (st_r == ST_WAIT)
      for (int k = 0; k < 3; k++) od_r[8*k +: 8] <= acc_nxt[k][2*FRAC +: 8];
  end

  assign q_ready = (st_r == ST_OUT) && o_ready;
  assign o_valid = (st_r == ST_OUT);
  assign o_data = od_r;
endmodule

@@ verif/tb_bilinear_image_scaler.sv @@
// Testbench for bilinear_image_scaler: fills the frame store, issues pixel requests
// and checks every interpolated beat against an in-bench bilinear predictor.
// Depends on bis_pkg and the bilinear_image_scaler RTL.
module tb_bilinear_image_scaler;
  import bis_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [47:0]           in_tdata;  // row, col, blue, green, red
  logic                  in_tuser;  // action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata; // out_blue, out_green, out_red
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  localparam int unsigned MAXW = 256;
  localparam int unsigned MAXH = 256;
  localparam int unsigned FB = 16;

  bilinear_image_scaler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  logic [23:0] pix_mem [0:MAXW*MAXH-1];
  bit          pix_written [0:MAXW*MAXH-1];
  logic [8:0]  width_reg, height_reg;
  logic [23:0] row_step_reg, col_step_reg;
  logic [23:0] expected_pix [$];
  int          fail_count = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int          stall_ticket = 0;
  int          stall_seen = 0;
  int          hold_left = 0;

  function automatic int unsigned eff_size(logic [8:0] v, int unsigned maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic void locate(input logic [23:0] step, input logic [11:0] idx,
                                 input int unsigned size, output int unsigned base,
                                 output int unsigned nb, output longint unsigned frac);
    longint unsigned pos, ip;
    pos = longint'(step) * longint'(idx);
    ip = pos >> FB;
    frac = pos & ((64'd1 << FB) - 1);
    if (ip > size - 1) begin
      ip = size - 1;
      frac = 0;
    end
    base = 32'(ip);
    nb = (base + 1 > size - 1) ? base - 1 : base + 1;
  endfunction

  function automatic bit reads_written(logic [11:0] row, logic [11:0] col);
    int unsigned r0, r1, c0, c1;
    longint unsigned fr, fc;
    locate(row_step_reg, row, eff_size(height_reg, MAXH), r0, r1, fr);
    locate(col_step_reg, col, eff_size(width_reg, MAXW), c0, c1, fc);
    return pix_written[r0*MAXW+c0] && pix_written[r0*MAXW+c1] &&
           pix_written[r1*MAXW+c0] && pix_written[r1*MAXW+c1];
  endfunction

  function automatic logic [23:0] blend_pixel(logic [11:0] row, logic [11:0] col);
    int unsigned r0, r1, c0, c1;
    longint unsigned fr, fc, one, w00, w01, w10, w11, acc;
    logic [23:0] p00, p01, p10, p11, res;
    one = 64'd1 << FB;
    locate(row_step_reg, row, eff_size(height_reg, MAXH), r0, r1, fr);
    locate(col_step_reg, col, eff_size(width_reg, MAXW), c0, c1, fc);
    w00 = (one - fr) * (one - fc);
    w01 = (one - fr) * fc;
    w10 = fr * (one - fc);
    w11 = fr * fc;
    p00 = pix_mem[r0*MAXW+c0];
    p01 = pix_mem[r0*MAXW+c1];
    p10 = pix_mem[r1*MAXW+c0];
    p11 = pix_mem[r1*MAXW+c1];
    for (int ch = 0; ch < 3; ch++) begin
      acc = longint'(p00[ch*8 +: 8]) * w00 + longint'(p01[ch*8 +: 8]) * w01 +
            longint'(p10[ch*8 +: 8]) * w10 + longint'(p11[ch*8 +: 8]) * w11;
      res[ch*8 +: 8] = 8'(acc >> (2*FB));
    end
    return res;
  endfunction

  task automatic send_beat(logic action, logic [11:0] row, logic [11:0] col, logic [23:0] bgr);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {bgr[23:16], bgr[15:8], bgr[7:0], col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (action == ACT_WRITE) begin
      if (row < MAXH && col < MAXW) begin
        pix_mem[row*MAXW+col] = bgr;
        pix_written[row*MAXW+col] = 1'b1;
      end
    end else begin
      expected_pix.insert(expected_pix.size(), blend_pixel(row, col));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:  width_reg = val[8:0];
      REG_SRC_HEIGHT: height_reg = val[8:0];
      REG_ROW_STEP:   row_step_reg = val;
      REG_COL_STEP:   col_step_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [23:0] w, logic [23:0] h, logic [23:0] rs, logic [23:0] cs);
    cfg_write(REG_SRC_WIDTH, w);
    cfg_write(REG_SRC_HEIGHT, h);
    cfg_write(REG_ROW_STEP, rs);
    cfg_write(REG_COL_STEP, cs);
  endtask

  task automatic load_image();
    int unsigned h, w;
    h = eff_size(height_reg, MAXH);
    w = eff_size(width_reg, MAXW);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        send_beat(ACT_WRITE, 12'(r), 12'(c), 24'($urandom));
  endtask

  task automatic random_traffic(int n);
    logic [11:0] row, col;
    int unsigned h, w;
    h = eff_size(height_reg, MAXH);
    w = eff_size(width_reg, MAXW);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1))
          send_beat(ACT_WRITE, 12'($urandom), 12'($urandom), 24'($urandom));
        else
          send_beat(ACT_WRITE, 12'($urandom_range(0, h-1)), 12'($urandom_range(0, w-1)),
                    24'($urandom));
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          row = 12'($urandom);
          col = 12'($urandom);
        end else begin
          row = 12'($urandom_range(0, 2*h));
          col = 12'($urandom_range(0, 2*w));
        end
        if (reads_written(row, col)) send_beat(ACT_REQUEST, row, col, 24'($urandom));
      end
    end
  endtask

  task automatic test_reset_geometry();
    int corner[4] = '{0, 1, 254, 255};
    foreach (corner[i])
      foreach (corner[j])
        send_beat(ACT_WRITE, 12'(corner[i]), 12'(corner[j]),
                  (i+j) % 2 ? 24'hFFFFFF : 24'h000000);
    send_beat(ACT_WRITE, 12'hFFF, 12'hFFF, 24'h123456);
    send_beat(ACT_WRITE, 12'd256, 12'd0, 24'hABCDEF);
    send_beat(ACT_WRITE, 12'd0, 12'd256, 24'hFEDCBA);
    send_beat(ACT_REQUEST, 12'd0, 12'd0, 24'hFFFFFF);
    send_beat(ACT_REQUEST, 12'd0, 12'd255, 24'h0);
    send_beat(ACT_REQUEST, 12'd255, 12'd0, 24'h0);
    send_beat(ACT_REQUEST, 12'd255, 12'd255, 24'h0);
    send_beat(ACT_REQUEST, 12'd254, 12'd254, 24'h0);
    send_beat(ACT_REQUEST, 12'hFFF, 12'hFFF, 24'h0);
    send_beat(ACT_REQUEST, 12'hFFF, 12'd0, 24'h0);
    wait_drained();
  endtask

  task automatic test_size_extremes();
    set_geometry(24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h000000);
    load_image();
    send_beat(ACT_REQUEST, 12'd1, 12'hFFF, 24'h0);
    random_traffic(40);
    wait_drained();
    set_geometry(24'h0001FF, 24'h000001, 24'h000000, 24'hFFFFFF);
    load_image();
    random_traffic(40);
    wait_drained();
    set_geometry(24'd2, 24'd2, 24'h010000, 24'h008000);
    load_image();
    random_traffic(20);
    wait_drained();
  endtask

  task automatic test_scaling_ratios(int phases, int n);
    int unsigned sw, sh, dw, dh;
    logic [23:0] rs, cs;
    for (int p = 0; p < phases; p++) begin
      sw = $urandom_range(2, 12);
      sh = $urandom_range(2, 12);
      dw = $urandom_range(2, 40);
      dh = $urandom_range(2, 40);
      rs = 24'(((sh - 1) << FB) / (dh - 1));
      cs = 24'(((sw - 1) << FB) / (dw - 1));
      if ($urandom_range(0, 3) == 0) rs = 24'($urandom);
      if ($urandom_range(0, 3) == 0) cs = 24'($urandom);
      set_geometry(24'(sw), 24'(sh), rs, cs);
      load_image();
      random_traffic(n);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    stall_ticket++;
    for (int i = 0; i < 40; i++)
      send_beat(ACT_REQUEST, 12'($urandom_range(0, 20)), 12'($urandom_range(0, 20)), 24'd0);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (expected_pix.size() == 0) begin
        $error("unexpected output beat %h", out_tdata);
        fail_count++;
      end else begin
        logic [23:0] exp_pix;
        exp_pix = expected_pix.pop_front();
        if (out_tdata[7:0] !== exp_pix[7:0]) begin
          $error("out_blue expected %0d actual %0d", exp_pix[7:0], out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[15:8] !== exp_pix[15:8]) begin
          $error("out_green expected %0d actual %0d", exp_pix[15:8], out_tdata[15:8]);
          fail_count++;
        end
        if (out_tdata[23:16] !== exp_pix[23:16]) begin
          $error("out_red expected %0d actual %0d", exp_pix[23:16], out_tdata[23:16]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_seen != stall_ticket) begin
      stall_seen <= stall_ticket;
      hold_left <= 300;
      out_tready <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
      hold_left <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #4000000;
    $display("bilinear_image_scaler test failed");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    for (int i = 0; i < MAXW*MAXH; i++) begin
      pix_mem[i] = '0;
      pix_written[i] = 1'b0;
    end
    width_reg = 9'd256;
    height_reg = 9'd256;
    row_step_reg = 24'h010000;
    col_step_reg = 24'h010000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_size_extremes();
    test_scaling_ratios(3, 30);
    test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_scaling_ratios(1, 30);
    wait_drained();
    if (fail_count == 0) begin
      $display("bilinear_image_scaler test passed");
    end else begin
      $display("bilinear_image_scaler test failed");
    end
    $finish;
  end
endmodule
